>>> rtl/core/streaming_pair_sum_detect_defines.svh
// Assertion macros used by the back stage of the streaming pair sum detector RTL.
`ifndef STREAMING_PAIR_SUM_DETECT_DEFINES_SVH
`define STREAMING_PAIR_SUM_DETECT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SPSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SPSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/spsd_pkg.sv
// Types and constants of the streaming pair sum detector.
`timescale 1ns / 1ps
`default_nettype none
package spsd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified item handed from front to back.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] comp;     // target - value, low 32 bits
    logic              comp_ok;  // complement fits in 32 bits signed
    logic              last;
  } spsd_item_t;

endpackage
`default_nettype wire

>>> rtl/core/spsd_front.sv
// Front stage: accepts items and forms the exact complement of each value.
`timescale 1ns / 1ps
`default_nettype none
module spsd_front
  import spsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DATA_W-1:0] target,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] element_value,
  input  wire logic              last_element,
  output logic                   push,
  output spsd_item_t             push_item,
  input  wire logic              q_ready
);

  logic              front_valid;
  spsd_item_t        front_item;
  logic              load;
  logic [DATA_W:0]   diff;

  assign push      = front_valid && q_ready;
  assign push_item = front_item;
  assign in_stall  = front_valid && !q_ready;
  assign load      = in_valid && !in_stall;

  // 33-bit signed difference never wraps.
  assign diff = {target[DATA_W-1], target} - {element_value[DATA_W-1], element_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (load) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_item.value   <= element_value;
      front_item.comp    <= diff[DATA_W-1:0];
      front_item.comp_ok <= (diff[DATA_W] == diff[DATA_W-1]);
      front_item.last    <= last_element;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/spsd_queue.sv
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module spsd_queue
  import spsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire spsd_item_t push_item,
  output logic            q_ready,
  input  wire logic       pop,
  output logic            q_valid,
  output spsd_item_t      q_item
);

  spsd_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;

  assign q_ready = (fill != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/spsd_back.sv
// Back stage: compares each complement against the stored set and emits results.
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_pair_sum_detect_defines.svh"
module spsd_back
  import spsd_pkg::*;
#(
  parameter int unsigned SET_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire spsd_item_t q_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            pair_found,
  output logic            capacity_overflow
);

  localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);

  logic [DATA_W-1:0] store [SET_DEPTH];
  logic [CNT_W-1:0]  count;
  logic              match_seen;
  logic              overflow_seen;
  logic [SET_DEPTH-1:0] hit_vec;
  logic              hit;
  logic              full;
  logic              out_free;
  logic              fire;
  logic              last_fire;

  // Every entry compared at once; entries at or above count are stale.
  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      hit_vec[i] = (CNT_W'(i) < count) && (store[i] == q_item.comp);
    end
  end

  assign hit       = q_item.comp_ok && (|hit_vec);
  assign full      = (count == CNT_W'(SET_DEPTH));
  assign out_free  = !out_valid || !out_stall;
  assign fire      = q_valid && (!q_item.last || out_free);
  assign pop       = fire;
  assign last_fire = fire && q_item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      match_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      if (q_item.last) begin
        count         <= '0;
        match_seen    <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (hit) begin
        match_seen <= 1'b1;
      end else if (!full) begin
        count <= count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hit && !full) begin
      store[count[IDX_W-1:0]] <= q_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && q_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_item.last) begin
      pair_found        <= match_seen || hit;
      capacity_overflow <= overflow_seen || (!hit && full);
    end
  end

  `SPSD_ASSERT_ALWAYS(a_count_bound, rst || (count <= CNT_W'(SET_DEPTH)), "store count past depth")
  `SPSD_ASSERT(a_ovf_needs_full, overflow_seen |-> full, "overflow flagged with room left")
  `SPSD_ASSERT(a_last_clears, last_fire |=> (count == '0 && !match_seen), "set not cleared")
  `SPSD_ASSERT(a_last_emits, last_fire |=> out_valid, "last item gave no result")

endmodule
`default_nettype wire

>>> rtl/core/streaming_pair_sum_detect.sv
// Streaming pair sum detector: top level.
// Usage:
//   Input channel (in_valid / in_stall) carries element_value and last_element,
//   one item per cycle unless stalled. Items through last_element = 1 form a set.
//   Output channel (out_valid / out_stall) gives one result per set:
//   pair_found and capacity_overflow. The user writes target_sum over
//   cfg_valid / cfg_ready (always ready) only while idle, unenforced in RTL.
// Throughput: one item per cycle when not stalled; the back stage compares
//   each complement against all SET_DEPTH stored values in parallel and
//   updates the store in the same cycle. A set's last item passes the
//   front register, a queue slot and the result register to the output.
// A four-entry queue sits between the complement stage and the compare stage,
//   so a stalled output only blocks the input once the queue has filled.
// Reset (rst, synchronous) empties the set, clears target_sum and drops any
//   pending result. While out_stall is high the result holds steady.
`timescale 1ns / 1ps
`default_nettype none
module streaming_pair_sum_detect
  import spsd_pkg::*;
#(
  parameter int unsigned SET_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DATA_W-1:0] target_sum,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] element_value,
  input  wire logic              last_element,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   pair_found,
  output logic                   capacity_overflow
);

  logic [DATA_W-1:0] target;
  logic              push;
  spsd_item_t        push_item;
  logic              q_ready;
  logic              q_valid;
  spsd_item_t        q_item;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_valid && cfg_ready) begin
      target <= target_sum;
    end
  end

  spsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .target        (target),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .last_element  (last_element),
    .push          (push),
    .push_item     (push_item),
    .q_ready       (q_ready)
  );

  spsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  spsd_back #(
    .SET_DEPTH (SET_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pair_found        (pair_found),
    .capacity_overflow (capacity_overflow)
  );

endmodule
`default_nettype wire
